@@ design/ahct_pkg.sv @@
// shared types and constants for the associative hit-count table
// no dependencies; used by the cell, the top level and the checker
`timescale 1ns / 1ps

package ahct_pkg;

    // operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_HIT    = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    localparam int KIND_W = 2;
    localparam int OFS_W  = 32;
    localparam int HITS_W = 16;
    localparam int KCNT_W = 9;

    localparam logic [KIND_W-1:0] KIND_NONE = '0;
    localparam logic [HITS_W-1:0] HIT_MAX   = '1;
    localparam logic [KCNT_W-1:0] KCNT_MAX  = '1;

    // search token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [1:0]        op;
        logic [KIND_W-1:0] kind;
        logic [OFS_W-1:0]  offset;
        logic              matched;
        logic              hole_seen;
        logic [HITS_W-1:0] hits;
        logic [KCNT_W-1:0] count;
    } token_t;

    // commands broadcast to every cell at once
    typedef struct packed {
        logic              clear;
        logic              insert;
        logic [KIND_W-1:0] kind;
        logic [OFS_W-1:0]  offset;
    } bcast_t;

endpackage

@@ design/ahct_cell.sv @@
// one table entry plus one stage of the search token chain
// depends on ahct_pkg
`timescale 1ns / 1ps

module ahct_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  ahct_pkg::token_t tok_i,
    input  ahct_pkg::bcast_t cmd_i,
    output ahct_pkg::token_t tok_o
);

    logic [ahct_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [ahct_pkg::OFS_W-1:0]  offset_reg, offset_next;
    logic [ahct_pkg::HITS_W-1:0] hits_reg, hits_next;
    logic                        cand_reg, cand_next;
    ahct_pkg::token_t            tok_reg, tok_next;

    logic                        empty;
    logic                        hit;
    logic [ahct_pkg::HITS_W-1:0] hits_inc;

    assign empty    = (kind_reg == ahct_pkg::KIND_NONE);
    assign hit      = !tok_i.matched && (kind_reg == tok_i.kind) && (offset_reg == tok_i.offset);
    assign hits_inc = (hits_reg == ahct_pkg::HIT_MAX) ? hits_reg
                                                      : hits_reg + ahct_pkg::HITS_W'(1);

    always_comb begin
        kind_next   = kind_reg;
        offset_next = offset_reg;
        hits_next   = hits_reg;
        cand_next   = cand_reg;
        tok_next    = tok_i;
        if (cmd_i.clear) begin
            kind_next   = ahct_pkg::KIND_NONE;
            offset_next = '0;
            hits_next   = '0;
        end else if (cmd_i.insert && cand_reg) begin
            // this cell was the first empty entry on the last add pass
            kind_next   = cmd_i.kind;
            offset_next = cmd_i.offset;
            hits_next   = '0;
        end else if (tok_i.valid) begin
            case (tok_i.op)
                ahct_pkg::OP_ADD: begin
                    cand_next          = empty && !tok_i.hole_seen;
                    tok_next.hole_seen = tok_i.hole_seen || empty;
                    if (hit) begin
                        hits_next        = hits_inc;
                        tok_next.matched = 1'b1;
                        tok_next.hits    = hits_inc;
                    end
                end
                ahct_pkg::OP_QUERY: begin
                    if (kind_reg == tok_i.kind && tok_i.count != ahct_pkg::KCNT_MAX) begin
                        tok_next.count = tok_i.count + ahct_pkg::KCNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= ahct_pkg::KIND_NONE;
            offset_reg <= '0;
            hits_reg   <= '0;
            cand_reg   <= 1'b0;
            tok_reg    <= '0;
        end else begin
            kind_reg   <= kind_next;
            offset_reg <= offset_next;
            hits_reg   <= hits_next;
            cand_reg   <= cand_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_o = tok_reg;

endmodule

@@ design/assoc_hit_count_table_unit.sv @@
// top level of the associative hit-count table: stream ports, sequencer, cell chain
// depends on ahct_pkg and ahct_cell
`timescale 1ns / 1ps

// channel  | dir | beat carries
// ---------+-----+--------------------------------------------------------------
// s_       | in  | tuser: op, var_kind; tdata: offset
// m_       | out | tuser: status; tdata: kind_count, hit_count
//
// add and query send a token down the chain of TABLE_DEPTH cells, one cell per
// cycle; clear and the unused opcode skip the chain and go straight to the result step
// clear empties every cell at once
// one item is in work at a time; a new input beat is taken while a result waits
// a stalled result holds the sequencer in its final step until the beat leaves
// reset (aresetn low, synchronous) empties the table and drops all valids

module assoc_hit_count_table_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] offset
    input  logic [3:0]  s_tuser,  // [1:0] op, [3:2] var_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [8:0] kind_count, [24:9] hit_count, [31:25] zero
    output logic [1:0]  m_tuser   // [1:0] status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t                      state_reg, state_next;
    ahct_pkg::token_t            launch_reg, launch_next;
    ahct_pkg::token_t            fin_reg, fin_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [1:0]                  status_reg, status_next;
    logic [ahct_pkg::KCNT_W-1:0] kcount_reg, kcount_next;
    logic [ahct_pkg::HITS_W-1:0] hcount_reg, hcount_next;

    ahct_pkg::token_t            tok [TABLE_DEPTH+1];
    ahct_pkg::bcast_t            cmd;

    logic                        s_beat;
    logic                        out_free;
    logic [1:0]                  in_op;
    logic [ahct_pkg::KIND_W-1:0] in_kind;
    logic [ahct_pkg::OFS_W-1:0]  in_offset;

    assign in_op     = s_tuser[1:0];
    assign in_kind   = s_tuser[3:2];
    assign in_offset = s_tdata[31:0];

    assign s_tready = (state_reg == S_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // the chain: token enters at cell 0 and leaves the last cell on tok[TABLE_DEPTH]
    assign tok[0] = launch_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            ahct_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .tok_i   (tok[gi]),
                .cmd_i   (cmd),
                .tok_o   (tok[gi+1])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        launch_next   = '0;
        fin_next      = fin_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        kcount_next   = kcount_reg;
        hcount_next   = hcount_reg;

        cmd.clear  = s_beat && (in_op == ahct_pkg::OP_CLEAR);
        cmd.insert = 1'b0;
        cmd.kind   = fin_reg.kind;
        cmd.offset = fin_reg.offset;

        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    // token built from the beat; clear and unused op skip the chain
                    fin_next        = '0;
                    fin_next.op     = in_op;
                    fin_next.kind   = in_kind;
                    fin_next.offset = in_offset;
                    if (in_op == ahct_pkg::OP_ADD || in_op == ahct_pkg::OP_QUERY) begin
                        launch_next       = fin_next;
                        launch_next.valid = 1'b1;
                        state_next        = S_RUN;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RUN: begin
                if (tok[TABLE_DEPTH].valid) begin
                    fin_next   = tok[TABLE_DEPTH];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    status_next   = ahct_pkg::ST_DONE;
                    kcount_next   = '0;
                    hcount_next   = '0;
                    case (fin_reg.op)
                        ahct_pkg::OP_ADD: begin
                            if (fin_reg.matched) begin
                                status_next = ahct_pkg::ST_HIT;
                                hcount_next = fin_reg.hits;
                            end else if (fin_reg.hole_seen) begin
                                // first empty cell takes the entry
                                status_next = ahct_pkg::ST_INSERT;
                                cmd.insert  = 1'b1;
                            end else begin
                                status_next = ahct_pkg::ST_FULL;
                            end
                        end
                        ahct_pkg::OP_QUERY: begin
                            kcount_next = fin_reg.count;
                        end
                        default: begin
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            launch_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            launch_reg   <= launch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        fin_reg    <= fin_next;
        status_reg <= status_next;
        kcount_reg <= kcount_next;
        hcount_reg <= hcount_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, hcount_reg, kcount_reg};

endmodule

@@ design/ahct_checker.sv @@
// port-level checks for assoc_hit_count_table_unit, attached by bind
// depends on ahct_pkg
`timescale 1ns / 1ps

module ahct_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one item at a time: the input side closes after each beat
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second input beat taken while busy");

    // kind count only on a done status, hit count only on a hit
    a_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ahct_pkg::ST_DONE || m_tdata[8:0] == 9'd0) &&
                     (m_tuser == ahct_pkg::ST_HIT || m_tdata[24:9] == 16'd0))
        else $error("result fields inconsistent with status");

endmodule

bind assoc_hit_count_table_unit ahct_checker u_ahct_checker (.*);
